// ===== rtl/core/xcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfr_pkg
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package xcfr_pkg;

  // command codes carried in s_tuser
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_READ = 2'd1,
    CMD_POP  = 2'd2
  } cmd_t;

  // frame parser phase, the unused code is treated as hunting
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEATER     = 1'd1;

  localparam logic [3:0] CONTROLLER_RESET = 4'd15;
  localparam logic [3:0] HEATER_RESET     = 4'd4;
  localparam logic [7:0] MIN_LENGTH       = 8'd2;

  // per-beat result handed from the parser to the output stage
  typedef struct packed {
    logic       frame_done;
    logic       frame_good;
    logic       packet_present;
    logic [7:0] packet_header;
    logic [7:0] packet_length;
    logic       rd_pending;
  } result_t;

endpackage

// ===== rtl/core/xcfr_ram.sv =====
// ----------------------------------------------------------------------------
// xcfr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module xcfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/xcfr_parser.sv =====
// ----------------------------------------------------------------------------
// xcfr_parser
// Header hunt, length check, running xor and packet slot bookkeeping.
// ----------------------------------------------------------------------------
module xcfr_parser #(
  parameter int unsigned PAYLOAD_CAPACITY = 64,
  parameter int unsigned AW               = 7
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [3:0]                           cfg_data,
  input  logic                                 take,
  input  logic [1:0]                           cmd,
  input  logic [7:0]                           rx_byte,
  input  logic [5:0]                           read_index,
  output xcfr_pkg::result_t                    res,
  output logic                                 wr_en,
  output logic [AW-1:0]                        wr_addr,
  output logic [7:0]                           wr_data,
  output logic [AW-1:0]                        rd_addr
);

  import xcfr_pkg::*;

  localparam logic [7:0]    CAP_B  = 8'(PAYLOAD_CAPACITY);
  localparam logic [AW-1:0] CAP_AW = AW'(PAYLOAD_CAPACITY);

  logic [3:0] controller_address;
  logic [3:0] heater_address;

  phase_t     phase, phase_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] frame_header, frame_header_next;
  logic [7:0] frame_length, frame_length_next;
  logic       bank_select, bank_select_next;
  logic       slot_full, slot_full_next;
  logic [7:0] slot_header, slot_header_next;
  logic [7:0] slot_length, slot_length_next;

  logic [7:0] hdr_a;
  logic [7:0] hdr_b;
  logic       last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_address <= CONTROLLER_RESET;
      heater_address     <= HEATER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CONTROLLER: controller_address <= cfg_data;
        CFG_HEATER:     heater_address     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      byte_count   <= '0;
      running_xor  <= '0;
      frame_header <= '0;
      frame_length <= '0;
      bank_select  <= 1'b0;
      slot_full    <= 1'b0;
      slot_header  <= '0;
      slot_length  <= '0;
    end else if (take) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      running_xor  <= running_xor_next;
      frame_header <= frame_header_next;
      frame_length <= frame_length_next;
      bank_select  <= bank_select_next;
      slot_full    <= slot_full_next;
      slot_header  <= slot_header_next;
      slot_length  <= slot_length_next;
    end
  end

  assign hdr_a     = {controller_address, heater_address};
  assign hdr_b     = {heater_address, controller_address};
  assign last_byte = ({1'b0, byte_count} + 9'd1) >= {1'b0, frame_length};

  // frames are built in the bank not holding the stored packet
  assign wr_data = rx_byte;
  assign wr_addr = bank_select ? AW'(byte_count)
                               : CAP_AW + AW'(byte_count);
  assign rd_addr = bank_select ? CAP_AW + AW'(read_index)
                               : AW'(read_index);

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    running_xor_next  = running_xor;
    frame_header_next = frame_header;
    frame_length_next = frame_length;
    bank_select_next  = bank_select;
    slot_full_next    = slot_full;
    slot_header_next  = slot_header;
    slot_length_next  = slot_length;
    res               = '0;
    wr_en             = 1'b0;

    case (cmd)
      CMD_BYTE: begin
        case (phase)
          PH_LEN: begin
            if (rx_byte < MIN_LENGTH || rx_byte > CAP_B) begin
              phase_next = PH_HUNT;
            end else begin
              frame_length_next = rx_byte;
              byte_count_next   = '0;
              running_xor_next  = running_xor ^ rx_byte;
              phase_next        = PH_DATA;
            end
          end
          PH_DATA: begin
            wr_en = take && (byte_count < CAP_B);
            if (last_byte) begin
              res.frame_done = 1'b1;
              if (rx_byte == running_xor) begin
                res.frame_good   = 1'b1;
                bank_select_next = ~bank_select;
                slot_full_next   = 1'b1;
                slot_header_next = frame_header;
                slot_length_next = frame_length;
              end
              phase_next      = PH_HUNT;
              byte_count_next = '0;
            end else begin
              running_xor_next = running_xor ^ rx_byte;
              byte_count_next  = byte_count + 8'd1;
            end
          end
          default: begin
            phase_next = PH_HUNT;
            if (rx_byte == hdr_a || rx_byte == hdr_b) begin
              frame_header_next = rx_byte;
              running_xor_next  = rx_byte;
              byte_count_next   = '0;
              phase_next        = PH_LEN;
            end
          end
        endcase
      end
      CMD_READ: begin
        if (slot_full) begin
          res.packet_present = 1'b1;
          res.rd_pending     = ({2'b00, read_index} < slot_length) &&
                               ({2'b00, read_index} < CAP_B);
        end
      end
      CMD_POP: begin
        if (slot_full) begin
          res.packet_present = 1'b1;
          res.packet_header  = slot_header;
          res.packet_length  = slot_length;
          slot_full_next     = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/xcfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// xcfr_out_stage
// Read-wait stage and output register with the master-side handshake.
// ----------------------------------------------------------------------------
module xcfr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  xcfr_pkg::result_t res,
  input  logic [7:0]        ram_q,
  output logic              ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,
  output logic [2:0]        m_tuser
);

  import xcfr_pkg::*;

  logic       s1_valid;
  result_t    s1_res;
  logic       s1_move;
  logic [7:0] out_header;
  logic [7:0] out_length;
  logic [7:0] out_data;
  logic [2:0] out_flags;

  assign s1_move = s1_valid && (!m_tvalid || m_tready);
  assign ready   = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_res <= res;
    end
    if (s1_move) begin
      out_flags  <= {s1_res.packet_present, s1_res.frame_good, s1_res.frame_done};
      out_header <= s1_res.packet_header;
      out_length <= s1_res.packet_length;
      // ram output is held while this item waits, since reads fire only on take
      out_data   <= s1_res.rd_pending ? ram_q : 8'd0;
    end
  end

  assign m_tuser = out_flags;
  assign m_tdata = {out_data, out_length, out_header};

endmodule

// ===== rtl/core/xor_checked_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_top
// Length-prefixed, xor-checked frame receiver with a single packet slot.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per beat: s_tuser is the command (received byte,
//   read a stored payload byte, pop the stored packet), s_tdata the line byte
//   and the read index. m_* returns exactly one result beat per input beat.
//   cfg_* writes the controller and heater addresses; cfg_ready is always
//   high and writes are expected only while the block is idle.
//   An input beat passes the read-wait stage (the registered read of the
//   payload buffer RAM, two ping-pong banks of PAYLOAD_CAPACITY bytes) and
//   the output register; one beat per cycle is sustained with m_tready high.
//   A good frame swaps the banks, so the stored packet is never overwritten
//   by a frame in progress.
//   Reset clears the parser to header hunting, empties the slot and restores
//   the default addresses; the buffer contents need no clearing.
//   When the receiver holds m_tready low, up to two beats are buffered and
//   s_tready then drops until the output moves again.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver_top #(
  parameter int unsigned PAYLOAD_CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,   // rx_byte[7:0], read_index[13:8]
  input  logic [1:0]                         s_tuser,   // cmd[1:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // packet_header[7:0], packet_length[15:8], read_data[23:16]
  output logic [23:0]                        m_tdata,
  // frame_done[0], frame_good[1], packet_present[2]
  output logic [2:0]                         m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [3:0]                         cfg_data
);

  import xcfr_pkg::*;

  localparam int unsigned DEPTH = 2 * PAYLOAD_CAPACITY;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic          take;
  result_t       res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_q;

  assign cfg_ready = 1'b1;
  assign take      = s_tvalid && s_tready;

  xcfr_parser #(
    .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY),
    .AW               (AW)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .cmd        (s_tuser),
    .rx_byte    (s_tdata[7:0]),
    .read_index (s_tdata[13:8]),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr)
  );

  xcfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (take),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  xcfr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .res      (res),
    .ram_q    (ram_q),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
